// File: sv/utf8sd_pkg.sv
// utf8sd_pkg: status codes, range limits and the per-byte decode step
// for the UTF-8 stream decoder. No dependencies.
`default_nettype none

package utf8sd_pkg;

  typedef enum logic [1:0] {
    StIncomplete = 2'd0,
    StChar       = 2'd1,
    StNul        = 2'd2,
    StError      = 2'd3
  } status_e;

  localparam int unsigned ValueW   = 26;
  localparam int unsigned CpW      = 21;
  localparam int unsigned OwedW    = 3;

  localparam logic [ValueW-1:0] SurrogateLo = 26'h000D800;
  localparam logic [ValueW-1:0] SurrogateHi = 26'h000E000;
  localparam logic [ValueW-1:0] MaxScalar   = 26'h010FFFF;

  // result fields plus the next decoder state
  typedef struct packed {
    status_e             status;
    logic [CpW-1:0]      code_point;
    logic [OwedW-1:0]    pending;
    logic [ValueW-1:0]   value;
    logic [OwedW-1:0]    owed;
  } step_t;

  // end of a sequence: state clears, value is classified
  function automatic step_t finish(input logic [ValueW-1:0] v);
    step_t r;
    r = '0;
    r.status = StError;
    if (v == '0) begin
      r.status = StNul;
    end else if ((v >= SurrogateLo && v < SurrogateHi) || v > MaxScalar) begin
      r.status = StError;
    end else begin
      r.status     = StChar;
      r.code_point = v[CpW-1:0];
    end
    return r;
  endfunction

  function automatic step_t decode_step(input logic [7:0]        b,
                                        input logic [ValueW-1:0] value,
                                        input logic [OwedW-1:0]  owed);
    step_t             r;
    logic              is_tail;
    logic [ValueW-1:0] merged;
    r       = '0;
    r.status = StError;
    is_tail = (b[7:6] == 2'b10);
    merged  = {value[ValueW-7:0], b[5:0]};
    if (is_tail != (owed != '0)) begin
      r        = '0;
      r.status = StError;
    end else if (owed == '0) begin
      r.status = StIncomplete;
      unique case (b[7:4]) inside
        4'b110?: begin
          r.value = {21'd0, b[4:0]};
          r.owed  = 3'd1;
        end
        4'b1110: begin
          r.value = {22'd0, b[3:0]};
          r.owed  = 3'd2;
        end
        4'b1111: begin
          if (!b[3]) begin
            r.value = {23'd0, b[2:0]};
            r.owed  = 3'd3;
          end else begin
            r.value = {24'd0, b[1:0]};
            r.owed  = 3'd4;
          end
        end
        default: r = finish({19'd0, b[6:0]});
      endcase
      r.pending = r.owed;
    end else if (owed > 3'd1) begin
      r.status  = StIncomplete;
      r.value   = merged;
      r.owed    = owed - 3'd1;
      r.pending = owed - 3'd1;
    end else begin
      r = finish(merged);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
// utf8_stream_decoder: byte-serial UTF-8 decoder, one result per byte.
// Depends on utf8sd_pkg (status codes, decode step).
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_byte_i    | sink
//  out     | out_valid_o, out_ready_i, status_o,  | source
//          | code_point_o, bytes_pending_o        |
//
// One byte per cycle sustained while the output is not stalled; each byte
// passes the input register, then is decoded into the result register;
// the decode step and the owed/partial state update are combinational.
// Reset clears both valid flags and the decoder state; no sequence is open.
// A stalled output holds; the input register takes a byte while it is empty
// or the result register is empty or being drained.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output utf8sd_pkg::status_e      status_o,
  output logic [20:0]              code_point_o,
  output logic [2:0]               bytes_pending_o
);
  import utf8sd_pkg::*;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [CpW-1:0]    code_point_q;
  logic [OwedW-1:0]  pending_q;
  logic [ValueW-1:0] value_q;
  logic [OwedW-1:0]  owed_q;

  logic  out_free;
  logic  s1_fire;
  step_t step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign step       = decode_step(in_byte_q, value_q, owed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      owed_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (s1_fire) begin
        value_q <= step.value;
        owed_q  <= step.owed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (s1_fire) begin
      status_q     <= step.status;
      code_point_q <= step.code_point;
      pending_q    <= step.pending;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign code_point_o    = code_point_q;
  assign bytes_pending_o = pending_q;

  // pending count only on incomplete results, and never a code point there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == StIncomplete) == (bytes_pending_o != '0)))
    else $error("pending count does not match status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StIncomplete |-> code_point_o == '0)
    else $error("code point on incomplete result");

  // a finished or failed sequence leaves no open state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && step.status != StIncomplete |=> owed_q == '0 && value_q == '0)
    else $error("state not cleared after sequence end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= 3'd4)
    else $error("owed count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StChar |->
      code_point_o != '0 && (code_point_o < 21'h00D800 || code_point_o >= 21'h00E000))
    else $error("invalid scalar reported as character");

endmodule

`default_nettype wire
